FILE: design/versatile_interface_adapter_core_macros.svh
// assertion macros for the interface adapter core
// used by design/versatile_interface_adapter_core.sv, expects aclk and aresetn in scope
`ifndef VERSATILE_INTERFACE_ADAPTER_CORE_MACROS_SVH
`define VERSATILE_INTERFACE_ADAPTER_CORE_MACROS_SVH

// same-cycle implication
`define VIA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VIA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/via_pkg.sv
// types and constants for the interface adapter core
// no dependencies
`timescale 1ns / 1ps

package via_pkg;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    typedef logic [3:0] reg_idx_t;

    localparam reg_idx_t REG_ORB  = 4'h0;
    localparam reg_idx_t REG_ORA  = 4'h1;
    localparam reg_idx_t REG_DDRB = 4'h2;
    localparam reg_idx_t REG_DDRA = 4'h3;
    localparam reg_idx_t REG_T1CL = 4'h4;
    localparam reg_idx_t REG_T1CH = 4'h5;
    localparam reg_idx_t REG_T1LL = 4'h6;
    localparam reg_idx_t REG_T1LH = 4'h7;
    localparam reg_idx_t REG_T2CL = 4'h8;
    localparam reg_idx_t REG_T2CH = 4'h9;
    localparam reg_idx_t REG_SR   = 4'ha;
    localparam reg_idx_t REG_ACR  = 4'hb;
    localparam reg_idx_t REG_PCR  = 4'hc;
    localparam reg_idx_t REG_IFR  = 4'hd;
    localparam reg_idx_t REG_IER  = 4'he;
    localparam reg_idx_t REG_ORA2 = 4'hf;

    // interrupt flag bit positions
    localparam int IRQ_T1 = 6;
    localparam int IRQ_T2 = 5;
    localparam int IRQ_SR = 2;

    // shift register modes, acr bits 4:2
    localparam logic [2:0] SR_IN_T2    = 3'b001;
    localparam logic [2:0] SR_IN_SYS   = 3'b010;
    localparam logic [2:0] SR_OUT_FREE = 3'b100;
    localparam logic [2:0] SR_OUT_T2   = 3'b101;
    localparam logic [2:0] SR_OUT_SYS  = 3'b110;

    // control line modes
    localparam logic [1:0] PCR_STROBE_MODE = 2'b10;
    localparam logic [2:0] PCR_PULSE_MODE  = 3'b101;
    localparam logic [2:0] PCR_LOW_MODE    = 3'b110;

    localparam logic [3:0] SR_BITS_DONE = 4'd8;

endpackage

FILE: design/versatile_interface_adapter_core.sv
// interface adapter core: ports, two timers, shift register, interrupt logic
// depends on via_pkg and versatile_interface_adapter_core_macros.svh
//
// channel  direction  handshake          payload
// s_       in         s_valid/s_ready    cmd, reg_index, write_data, compare_in
// m_       out        m_valid/m_ready    read_data, irq, pb7, ca2, cb2 levels, ports
//
// one transaction per cycle while s_ready is high; next state and result are formed
// combinationally, registered on acceptance, and appear on the following cycle
// s_ready is high while the result register is empty or being taken
// reset is synchronous and initialises all control and adapter state but read data
`timescale 1ns / 1ps
`include "versatile_interface_adapter_core_macros.svh"

module versatile_interface_adapter_core #(
    parameter int TIMER_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_cmd,
    input  via_pkg::reg_idx_t   s_reg_index,
    input  logic [7:0]          s_write_data,
    input  logic                s_compare_in,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_read_data,
    output logic                m_irq,
    output logic                m_timer1_pb7,
    output logic                m_ca2_out,
    output logic                m_cb2_handshake_out,
    output logic                m_cb2_shift_out,
    output logic [7:0]          m_port_a_out,
    output logic [7:0]          m_port_b_out
);
    import via_pkg::*;

    logic                  m_valid_reg;
    logic [7:0]            read_data_reg, read_data_next;
    logic [7:0]            out_a_reg, out_a_next, out_b_reg, out_b_next;
    logic [7:0]            dir_a_reg, dir_a_next, dir_b_reg, dir_b_next;
    logic [TIMER_BITS-1:0] t1_count_reg, t1_count_next, t2_count_reg, t2_count_next;
    logic [7:0]            t1_latch_low_reg, t1_latch_low_next;
    logic [7:0]            t1_latch_high_reg, t1_latch_high_next;
    logic [7:0]            t2_latch_low_reg, t2_latch_low_next;
    logic                  t1_running_reg, t1_running_next, t1_armed_reg, t1_armed_next;
    logic                  pb7_reg, pb7_next;
    logic                  t2_running_reg, t2_running_next, t2_armed_reg, t2_armed_next;
    logic [7:0]            shift_data_reg, shift_data_next;
    logic [3:0]            shift_count_reg, shift_count_next;
    logic [7:0]            shift_div_reg, shift_div_next;
    logic                  shift_phase_reg, shift_phase_next;
    logic [7:0]            acr_reg, acr_next, pcr_reg, pcr_next;
    logic [6:0]            irq_flags_reg, irq_flags_next;
    logic [6:0]            irq_en_reg, irq_en_next;
    logic                  ca2_reg, ca2_next, cb2_hand_reg, cb2_hand_next;
    logic                  cb2_shift_reg, cb2_shift_next;

    logic                  accept;
    logic                  irq_now;
    logic [31:0]           t1_ext, t2_ext, t1_load32, t2_load32;
    logic [TIMER_BITS-1:0] t1_dec, t2_dec;
    logic [7:0]            div_dec;
    logic                  t2shift;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign irq_now = |(irq_flags_reg & irq_en_reg);

    assign t1_ext    = 32'(t1_count_reg);
    assign t2_ext    = 32'(t2_count_reg);
    assign t1_load32 = {16'h0000, t1_latch_high_reg, t1_latch_low_reg};
    assign t2_load32 = {16'h0000, s_write_data, t2_latch_low_reg};
    assign t1_dec    = t1_count_reg - TIMER_BITS'(1);
    assign t2_dec    = t2_count_reg - TIMER_BITS'(1);
    assign div_dec   = shift_div_reg - 8'd1;

    always_comb begin
        read_data_next     = '0;
        out_a_next         = out_a_reg;
        out_b_next         = out_b_reg;
        dir_a_next         = dir_a_reg;
        dir_b_next         = dir_b_reg;
        t1_count_next      = t1_count_reg;
        t2_count_next      = t2_count_reg;
        t1_latch_low_next  = t1_latch_low_reg;
        t1_latch_high_next = t1_latch_high_reg;
        t2_latch_low_next  = t2_latch_low_reg;
        t1_running_next    = t1_running_reg;
        t1_armed_next      = t1_armed_reg;
        pb7_next           = pb7_reg;
        t2_running_next    = t2_running_reg;
        t2_armed_next      = t2_armed_reg;
        shift_data_next    = shift_data_reg;
        shift_count_next   = shift_count_reg;
        shift_div_next     = shift_div_reg;
        shift_phase_next   = shift_phase_reg;
        acr_next           = acr_reg;
        pcr_next           = pcr_reg;
        irq_flags_next     = irq_flags_reg;
        irq_en_next        = irq_en_reg;
        ca2_next           = ca2_reg;
        cb2_hand_next      = cb2_hand_reg;
        cb2_shift_next     = cb2_shift_reg;
        t2shift            = 1'b0;

        case (s_cmd)
            CMD_READ: begin
                case (s_reg_index)
                    REG_ORB: begin
                        if (acr_reg[7]) begin
                            read_data_next = {pb7_reg, out_b_reg[6], s_compare_in,
                                              out_b_reg[4:0]};
                        end else begin
                            read_data_next = {out_b_reg[7:6], s_compare_in,
                                              out_b_reg[4:0]};
                        end
                    end
                    REG_ORA: begin
                        if (pcr_reg[3:2] == PCR_STROBE_MODE) begin
                            ca2_next = 1'b0;
                        end
                        read_data_next = out_a_reg;
                    end
                    REG_ORA2: read_data_next = out_a_reg;
                    REG_DDRB: read_data_next = dir_b_reg;
                    REG_DDRA: read_data_next = dir_a_reg;
                    REG_T1CL: begin
                        read_data_next         = t1_ext[7:0];
                        irq_flags_next[IRQ_T1] = 1'b0;
                        t1_running_next        = 1'b0;
                        t1_armed_next          = 1'b0;
                        pb7_next               = 1'b1;
                    end
                    REG_T1CH: read_data_next = t1_ext[15:8];
                    REG_T1LL: read_data_next = t1_latch_low_reg;
                    REG_T1LH: read_data_next = t1_latch_high_reg;
                    REG_T2CL: begin
                        read_data_next         = t2_ext[7:0];
                        irq_flags_next[IRQ_T2] = 1'b0;
                        t2_running_next        = 1'b0;
                        t2_armed_next          = 1'b0;
                    end
                    REG_T2CH: read_data_next = t2_ext[15:8];
                    REG_SR: begin
                        read_data_next         = shift_data_reg;
                        irq_flags_next[IRQ_SR] = 1'b0;
                        shift_count_next       = '0;
                        shift_phase_next       = 1'b1;
                    end
                    REG_ACR: read_data_next = acr_reg;
                    REG_PCR: read_data_next = pcr_reg;
                    REG_IFR: read_data_next = {irq_now, irq_flags_reg};
                    REG_IER: read_data_next = {1'b1, irq_en_reg};
                    default: read_data_next = '0;
                endcase
            end
            CMD_WRITE: begin
                case (s_reg_index)
                    REG_ORB: begin
                        out_b_next = s_write_data;
                        if (pcr_reg[7:6] == PCR_STROBE_MODE) begin
                            cb2_hand_next = 1'b0;
                        end
                    end
                    REG_ORA: begin
                        if (pcr_reg[3:2] == PCR_STROBE_MODE) begin
                            ca2_next = 1'b0;
                        end
                        out_a_next = s_write_data;
                    end
                    REG_ORA2: out_a_next = s_write_data;
                    REG_DDRB: dir_b_next = s_write_data;
                    REG_DDRA: dir_a_next = s_write_data;
                    REG_T1CL: t1_latch_low_next = s_write_data;
                    REG_T1CH: begin
                        t1_latch_high_next     = s_write_data;
                        t1_count_next          = TIMER_BITS'({16'h0000, s_write_data,
                                                              t1_latch_low_reg});
                        irq_flags_next[IRQ_T1] = 1'b0;
                        t1_running_next        = 1'b1;
                        t1_armed_next          = 1'b1;
                        pb7_next               = 1'b0;
                    end
                    REG_T1LL: t1_latch_low_next = s_write_data;
                    REG_T1LH: t1_latch_high_next = s_write_data;
                    REG_T2CL: t2_latch_low_next = s_write_data;
                    REG_T2CH: begin
                        t2_count_next          = t2_load32[TIMER_BITS-1:0];
                        irq_flags_next[IRQ_T2] = 1'b0;
                        t2_running_next        = 1'b1;
                        t2_armed_next          = 1'b1;
                    end
                    REG_SR: begin
                        shift_data_next        = s_write_data;
                        irq_flags_next[IRQ_SR] = 1'b0;
                        shift_count_next       = '0;
                        shift_phase_next       = 1'b1;
                    end
                    REG_ACR: acr_next = s_write_data;
                    REG_PCR: begin
                        pcr_next      = s_write_data;
                        ca2_next      = (s_write_data[3:1] != PCR_LOW_MODE);
                        cb2_hand_next = (s_write_data[7:5] != PCR_LOW_MODE);
                    end
                    REG_IFR: irq_flags_next = irq_flags_reg & ~s_write_data[6:0];
                    REG_IER: begin
                        if (s_write_data[7]) begin
                            irq_en_next = irq_en_reg | s_write_data[6:0];
                        end else begin
                            irq_en_next = irq_en_reg & ~s_write_data[6:0];
                        end
                    end
                    default: out_a_next = out_a_reg;
                endcase
            end
            CMD_TICK: begin
                // timer 1
                if (t1_running_reg) begin
                    t1_count_next = t1_dec;
                    if (t1_dec == '1) begin
                        if (acr_reg[6]) begin
                            irq_flags_next[IRQ_T1] = 1'b1;
                            pb7_next               = !pb7_reg;
                            t1_count_next          = t1_load32[TIMER_BITS-1:0];
                        end else if (t1_armed_reg) begin
                            irq_flags_next[IRQ_T1] = 1'b1;
                            pb7_next               = 1'b1;
                            t1_armed_next          = 1'b0;
                        end
                    end
                end
                // timer 2
                if (t2_running_reg && !acr_reg[5]) begin
                    t2_count_next = t2_dec;
                    if (t2_dec == '1 && t2_armed_reg) begin
                        irq_flags_next[IRQ_T2] = 1'b1;
                        t2_armed_next          = 1'b0;
                    end
                end
                // shift clock divider
                if (shift_div_reg == 8'd0) begin
                    shift_div_next   = t2_latch_low_reg;
                    t2shift          = shift_phase_reg;
                    shift_phase_next = !shift_phase_reg;
                end else begin
                    shift_div_next = div_dec;
                end
                // shift register
                if (!shift_count_reg[3]) begin
                    case (acr_reg[4:2])
                        SR_IN_T2: begin
                            if (t2shift) begin
                                shift_data_next  = {shift_data_reg[6:0], 1'b0};
                                shift_count_next = shift_count_reg + 4'd1;
                            end
                        end
                        SR_IN_SYS: begin
                            shift_data_next  = {shift_data_reg[6:0], 1'b0};
                            shift_count_next = shift_count_reg + 4'd1;
                        end
                        SR_OUT_FREE: begin
                            if (t2shift) begin
                                cb2_shift_next  = shift_data_reg[7];
                                shift_data_next = {shift_data_reg[6:0], shift_data_reg[7]};
                            end
                        end
                        SR_OUT_T2: begin
                            if (t2shift) begin
                                cb2_shift_next   = shift_data_reg[7];
                                shift_data_next  = {shift_data_reg[6:0], shift_data_reg[7]};
                                shift_count_next = shift_count_reg + 4'd1;
                            end
                        end
                        SR_OUT_SYS: begin
                            cb2_shift_next   = shift_data_reg[7];
                            shift_data_next  = {shift_data_reg[6:0], shift_data_reg[7]};
                            shift_count_next = shift_count_reg + 4'd1;
                        end
                        default: shift_count_next = shift_count_reg;
                    endcase
                    if (shift_count_next == SR_BITS_DONE) begin
                        irq_flags_next[IRQ_SR] = 1'b1;
                    end
                end
                // pulse mode restore
                if (pcr_reg[3:1] == PCR_PULSE_MODE) begin
                    ca2_next = 1'b1;
                end
                if (pcr_reg[7:5] == PCR_PULSE_MODE) begin
                    cb2_hand_next = 1'b1;
                end
            end
            default: read_data_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg       <= 1'b0;
            out_a_reg         <= '0;
            out_b_reg         <= '0;
            dir_a_reg         <= '0;
            dir_b_reg         <= '0;
            t1_count_reg      <= '0;
            t2_count_reg      <= '0;
            t1_latch_low_reg  <= '0;
            t1_latch_high_reg <= '0;
            t2_latch_low_reg  <= '0;
            t1_running_reg    <= 1'b0;
            t1_armed_reg      <= 1'b0;
            pb7_reg           <= 1'b1;
            t2_running_reg    <= 1'b0;
            t2_armed_reg      <= 1'b0;
            shift_data_reg    <= '0;
            shift_count_reg   <= SR_BITS_DONE;
            shift_div_reg     <= '0;
            shift_phase_reg   <= 1'b0;
            acr_reg           <= '0;
            pcr_reg           <= '0;
            irq_flags_reg     <= '0;
            irq_en_reg        <= '0;
            ca2_reg           <= 1'b1;
            cb2_hand_reg      <= 1'b1;
            cb2_shift_reg     <= 1'b0;
        end else begin
            if (accept) begin
                m_valid_reg       <= 1'b1;
                out_a_reg         <= out_a_next;
                out_b_reg         <= out_b_next;
                dir_a_reg         <= dir_a_next;
                dir_b_reg         <= dir_b_next;
                t1_count_reg      <= t1_count_next;
                t2_count_reg      <= t2_count_next;
                t1_latch_low_reg  <= t1_latch_low_next;
                t1_latch_high_reg <= t1_latch_high_next;
                t2_latch_low_reg  <= t2_latch_low_next;
                t1_running_reg    <= t1_running_next;
                t1_armed_reg      <= t1_armed_next;
                pb7_reg           <= pb7_next;
                t2_running_reg    <= t2_running_next;
                t2_armed_reg      <= t2_armed_next;
                shift_data_reg    <= shift_data_next;
                shift_count_reg   <= shift_count_next;
                shift_div_reg     <= shift_div_next;
                shift_phase_reg   <= shift_phase_next;
                acr_reg           <= acr_next;
                pcr_reg           <= pcr_next;
                irq_flags_reg     <= irq_flags_next;
                irq_en_reg        <= irq_en_next;
                ca2_reg           <= ca2_next;
                cb2_hand_reg      <= cb2_hand_next;
                cb2_shift_reg     <= cb2_shift_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            read_data_reg <= read_data_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_read_data         = read_data_reg;
    assign m_irq               = irq_now;
    assign m_timer1_pb7        = pb7_reg;
    assign m_ca2_out           = ca2_reg;
    assign m_cb2_handshake_out = cb2_hand_reg;
    assign m_cb2_shift_out     = cb2_shift_reg;
    assign m_port_a_out        = out_a_reg;
    assign m_port_b_out        = out_b_reg;

    `VIA_ASSERT_SAME(a_shift_count_range, 1'b1, shift_count_reg <= SR_BITS_DONE,
        "shift bit count above eight")
    `VIA_ASSERT_NEXT(a_accept_gives_result, accept, m_valid_reg,
        "accepted transaction produced no result")
    `VIA_ASSERT_NEXT(a_non_read_zero, accept && s_cmd != CMD_READ, m_read_data == 8'h00,
        "read data not zero for a non-read transaction")
    `VIA_ASSERT_NEXT(a_t1_low_read_stops,
        accept && s_cmd == CMD_READ && s_reg_index == REG_T1CL,
        !t1_running_reg && m_timer1_pb7 && !irq_flags_reg[IRQ_T1],
        "timer 1 low read did not stop timer 1")
    `VIA_ASSERT_NEXT(a_t1_high_write_starts,
        accept && s_cmd == CMD_WRITE && s_reg_index == REG_T1CH,
        t1_running_reg && t1_armed_reg && !m_timer1_pb7,
        "timer 1 high write did not start timer 1")

endmodule

FILE: bench/tb_versatile_interface_adapter_core.sv
// self-checking bench for versatile_interface_adapter_core: bus reads, writes and ticks
// against an in-bench prediction of ports, timers, shift register and irq logic
// depends on design/via_pkg.sv and the core rtl
`timescale 1ns / 1ps

module tb_versatile_interface_adapter_core;
    import via_pkg::*;

    localparam int TMR_W = 16;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef logic [TMR_W-1:0] tmr_t;

    typedef struct packed {
        logic [1:0] cmd;
        reg_idx_t   idx;
        logic [7:0] data;
        logic       cmp;
    } bus_op_t;

    typedef struct packed {
        logic [7:0] rd;
        logic       irq;
        logic       pb7;
        logic       ca2;
        logic       cb2_hs;
        logic       cb2_sr;
        logic [7:0] pa;
        logic [7:0] pb;
    } via_pins_t;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_cmd = CMD_READ;
    reg_idx_t   s_reg_index = REG_ORB;
    logic [7:0] s_write_data = 8'h00;
    logic       s_compare_in = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_read_data;
    logic       m_irq;
    logic       m_timer1_pb7;
    logic       m_ca2_out;
    logic       m_cb2_handshake_out;
    logic       m_cb2_shift_out;
    logic [7:0] m_port_a_out;
    logic [7:0] m_port_b_out;

    versatile_interface_adapter_core #(
        .TIMER_BITS(TMR_W)
    ) dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_cmd              (s_cmd),
        .s_reg_index        (s_reg_index),
        .s_write_data       (s_write_data),
        .s_compare_in       (s_compare_in),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_read_data        (m_read_data),
        .m_irq              (m_irq),
        .m_timer1_pb7       (m_timer1_pb7),
        .m_ca2_out          (m_ca2_out),
        .m_cb2_handshake_out(m_cb2_handshake_out),
        .m_cb2_shift_out    (m_cb2_shift_out),
        .m_port_a_out       (m_port_a_out),
        .m_port_b_out       (m_port_b_out)
    );

    bus_op_t   pending_ops[$];
    via_pins_t expected_pins[$];
    int        op_total = 0;
    int        fail_count = 0;
    logic      op_taken = 1'b0;

    // predicted adapter state
    logic [7:0] pa_out, pb_out, pa_dir, pb_dir;
    tmr_t       t1_cnt, t2_cnt;
    logic [7:0] t1_lo_latch, t1_hi_latch, t2_lo_latch;
    logic       t1_on, t1_armed, pb7_lvl, t2_on, t2_armed;
    logic [7:0] sr_data, sr_div;
    logic [3:0] sr_count;
    logic       sr_phase;
    logic [7:0] acr, pcr, ifr;
    logic [6:0] ier;
    logic       ca2_lvl, cb2_hs_lvl, cb2_sr_lvl;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [7:0] rbyte();
        return 8'($urandom);
    endfunction

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic reset_model();
        pa_out = 8'h00; pb_out = 8'h00; pa_dir = 8'h00; pb_dir = 8'h00;
        t1_cnt = '0; t2_cnt = '0;
        t1_lo_latch = 8'h00; t1_hi_latch = 8'h00; t2_lo_latch = 8'h00;
        t1_on = 1'b0; t1_armed = 1'b0; pb7_lvl = 1'b1;
        t2_on = 1'b0; t2_armed = 1'b0;
        sr_data = 8'h00; sr_count = SR_BITS_DONE; sr_div = 8'h00; sr_phase = 1'b0;
        acr = 8'h00; pcr = 8'h00; ifr = 8'h00; ier = 7'h00;
        ca2_lvl = 1'b1; cb2_hs_lvl = 1'b1; cb2_sr_lvl = 1'b0;
    endtask

    task automatic refresh_irq();
        ifr[7] = ((ifr[6:0] & ier) != 7'h00);
    endtask

    task automatic shift_out_bit();
        cb2_sr_lvl = sr_data[7];
        sr_data = {sr_data[6:0], cb2_sr_lvl};
    endtask

    task automatic bus_read(input reg_idx_t idx, input logic cmp, output logic [7:0] d);
        d = 8'h00;
        case (idx)
            REG_ORB: begin
                d = pb_out;
                d[5] = cmp;
                if (acr[7])
                    d[7] = pb7_lvl;
            end
            REG_ORA: begin
                if (pcr[3:2] == PCR_STROBE_MODE)
                    ca2_lvl = 1'b0;
                d = pa_out;
            end
            REG_ORA2: d = pa_out;
            REG_DDRB: d = pb_dir;
            REG_DDRA: d = pa_dir;
            REG_T1CL: begin
                d = t1_cnt[7:0];
                ifr[IRQ_T1] = 1'b0;
                t1_on = 1'b0; t1_armed = 1'b0; pb7_lvl = 1'b1;
                refresh_irq();
            end
            REG_T1CH: d = 8'(t1_cnt >> 8);
            REG_T1LL: d = t1_lo_latch;
            REG_T1LH: d = t1_hi_latch;
            REG_T2CL: begin
                d = t2_cnt[7:0];
                ifr[IRQ_T2] = 1'b0;
                t2_on = 1'b0; t2_armed = 1'b0;
                refresh_irq();
            end
            REG_T2CH: d = 8'(t2_cnt >> 8);
            REG_SR: begin
                d = sr_data;
                ifr[IRQ_SR] = 1'b0;
                sr_count = 4'd0; sr_phase = 1'b1;
                refresh_irq();
            end
            REG_ACR: d = acr;
            REG_PCR: d = pcr;
            REG_IFR: d = ifr;
            default: d = {1'b1, ier};
        endcase
    endtask

    task automatic bus_write(input reg_idx_t idx, input logic [7:0] v);
        case (idx)
            REG_ORB: begin
                pb_out = v;
                if (pcr[7:6] == PCR_STROBE_MODE)
                    cb2_hs_lvl = 1'b0;
            end
            REG_ORA: begin
                if (pcr[3:2] == PCR_STROBE_MODE)
                    ca2_lvl = 1'b0;
                pa_out = v;
            end
            REG_ORA2: pa_out = v;
            REG_DDRB: pb_dir = v;
            REG_DDRA: pa_dir = v;
            REG_T1CL, REG_T1LL: t1_lo_latch = v;
            REG_T1CH: begin
                t1_hi_latch = v;
                t1_cnt = tmr_t'({t1_hi_latch, t1_lo_latch});
                ifr[IRQ_T1] = 1'b0;
                t1_on = 1'b1; t1_armed = 1'b1; pb7_lvl = 1'b0;
                refresh_irq();
            end
            REG_T1LH: t1_hi_latch = v;
            REG_T2CL: t2_lo_latch = v;
            REG_T2CH: begin
                t2_cnt = tmr_t'({v, t2_lo_latch});
                ifr[IRQ_T2] = 1'b0;
                t2_on = 1'b1; t2_armed = 1'b1;
                refresh_irq();
            end
            REG_SR: begin
                sr_data = v;
                ifr[IRQ_SR] = 1'b0;
                sr_count = 4'd0; sr_phase = 1'b1;
                refresh_irq();
            end
            REG_ACR: acr = v;
            REG_PCR: begin
                pcr = v;
                ca2_lvl = (v[3:1] != PCR_LOW_MODE);
                cb2_hs_lvl = (v[7:5] != PCR_LOW_MODE);
            end
            REG_IFR: begin
                ifr = ifr & ~{1'b0, v[6:0]};
                refresh_irq();
            end
            default: begin
                if (v[7])
                    ier = ier | v[6:0];
                else
                    ier = ier & ~v[6:0];
                refresh_irq();
            end
        endcase
    endtask

    task automatic clock_tick();
        logic t2shift;
        t2shift = 1'b0;
        if (t1_on) begin
            t1_cnt = t1_cnt - 1'b1;
            if (t1_cnt == '1) begin
                if (acr[6]) begin
                    ifr[IRQ_T1] = 1'b1;
                    refresh_irq();
                    pb7_lvl = ~pb7_lvl;
                    t1_cnt = tmr_t'({t1_hi_latch, t1_lo_latch});
                end else if (t1_armed) begin
                    ifr[IRQ_T1] = 1'b1;
                    refresh_irq();
                    pb7_lvl = 1'b1;
                    t1_armed = 1'b0;
                end
            end
        end
        if (t2_on && !acr[5]) begin
            t2_cnt = t2_cnt - 1'b1;
            if (t2_cnt == '1 && t2_armed) begin
                ifr[IRQ_T2] = 1'b1;
                refresh_irq();
                t2_armed = 1'b0;
            end
        end
        sr_div = sr_div - 8'd1;
        if (sr_div == 8'hff) begin
            sr_div = t2_lo_latch;
            t2shift = sr_phase;
            sr_phase = ~sr_phase;
        end
        if (sr_count < SR_BITS_DONE) begin
            case (acr[4:2])
                SR_IN_T2: begin
                    if (t2shift) begin
                        sr_data = {sr_data[6:0], 1'b0};
                        sr_count = sr_count + 4'd1;
                    end
                end
                SR_IN_SYS: begin
                    sr_data = {sr_data[6:0], 1'b0};
                    sr_count = sr_count + 4'd1;
                end
                SR_OUT_FREE: begin
                    if (t2shift)
                        shift_out_bit();
                end
                SR_OUT_T2: begin
                    if (t2shift) begin
                        shift_out_bit();
                        sr_count = sr_count + 4'd1;
                    end
                end
                SR_OUT_SYS: begin
                    shift_out_bit();
                    sr_count = sr_count + 4'd1;
                end
                default: ;
            endcase
            if (sr_count == SR_BITS_DONE) begin
                ifr[IRQ_SR] = 1'b1;
                refresh_irq();
            end
        end
        if (pcr[3:1] == PCR_PULSE_MODE)
            ca2_lvl = 1'b1;
        if (pcr[7:5] == PCR_PULSE_MODE)
            cb2_hs_lvl = 1'b1;
    endtask

    task automatic predict_via_pins(input bus_op_t op, output via_pins_t res);
        logic [7:0] rd;
        rd = 8'h00;
        case (op.cmd)
            CMD_READ:  bus_read(op.idx, op.cmp, rd);
            CMD_WRITE: bus_write(op.idx, op.data);
            CMD_TICK:  clock_tick();
            default: ;
        endcase
        res.rd = rd;
        res.irq = ifr[7];
        res.pb7 = pb7_lvl;
        res.ca2 = ca2_lvl;
        res.cb2_hs = cb2_hs_lvl;
        res.cb2_sr = cb2_sr_lvl;
        res.pa = pa_out;
        res.pb = pb_out;
    endtask

    task automatic add_op(input logic [1:0] cmd, input reg_idx_t idx, input logic [7:0] data,
                          input logic cmp);
        bus_op_t op;
        op.cmd = cmd;
        op.idx = idx;
        op.data = data;
        op.cmp = cmp;
        pending_ops.push_back(op);
        op_total++;
    endtask

    // ticks with an occasional status read in between
    task automatic add_ticks(input int n, input reg_idx_t peek_a, input reg_idx_t peek_b);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0)
                add_op(CMD_READ, coin() ? peek_a : peek_b, rbyte(), coin());
            add_op(CMD_TICK, reg_idx_t'($urandom_range(0, 15)), rbyte(), coin());
        end
    endtask

    task automatic load_directed_ops();
        add_op(CMD_READ, REG_ORB, 8'h00, 1'b1);
        add_op(CMD_WRITE, REG_DDRB, 8'hff, 1'b0);
        add_op(CMD_WRITE, REG_ORB, 8'hff, 1'b1);
        add_op(CMD_READ, REG_ORB, 8'hff, 1'b0);
        add_op(CMD_UNUSED, REG_ORA2, 8'hff, 1'b1);
        add_op(CMD_WRITE, REG_PCR, 8'haa, 1'b0);
        add_op(CMD_READ, REG_ORA, 8'h00, 1'b0);
        add_op(CMD_TICK, REG_ORB, 8'h00, 1'b0);
        add_op(CMD_WRITE, REG_ORB, 8'h00, 1'b1);
        add_op(CMD_TICK, REG_ORA2, 8'hff, 1'b1);
        add_op(CMD_READ, REG_ORA2, 8'h00, 1'b0);
        add_op(CMD_WRITE, REG_IER, 8'hff, 1'b0);
        add_op(CMD_WRITE, REG_T1CL, 8'h00, 1'b0);
        add_op(CMD_WRITE, REG_T1CH, 8'h00, 1'b0);
        add_op(CMD_TICK, REG_ORB, 8'h00, 1'b0);
        add_op(CMD_READ, REG_T1CL, 8'h00, 1'b1);
        add_op(CMD_WRITE, REG_ACR, 8'h08, 1'b0);
        add_op(CMD_WRITE, REG_SR, 8'hff, 1'b0);
        add_op(CMD_TICK, REG_ORB, 8'h00, 1'b0);
        add_op(CMD_WRITE, REG_ACR, 8'hd0, 1'b1);
        add_op(CMD_WRITE, REG_SR, 8'h81, 1'b0);
        add_op(CMD_TICK, REG_ORB, 8'h00, 1'b0);
        add_op(CMD_READ, REG_SR, 8'h00, 1'b0);
        add_op(CMD_READ, REG_IER, 8'h00, 1'b1);
        add_op(CMD_READ, REG_IFR, 8'h00, 1'b0);
    endtask

    task automatic load_random_ops();
        int         n;
        logic [7:0] lo, hi, v;
        logic [2:0] mode;
        while (op_total < 1820) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    if ($urandom_range(0, 7) == 0) begin
                        lo = rbyte();
                        hi = rbyte();
                    end else begin
                        lo = 8'($urandom_range(0, 40));
                        hi = 8'h00;
                    end
                    add_op(CMD_WRITE, coin() ? REG_T1CL : REG_T1LL, lo, coin());
                    add_op(CMD_WRITE, REG_ACR, rbyte(), coin());
                    if (coin())
                        add_op(CMD_WRITE, REG_IER, rbyte() | 8'hc0, coin());
                    add_op(CMD_WRITE, REG_T1CH, hi, coin());
                    add_ticks(int'(lo) + $urandom_range(1, 30), REG_T1CH, REG_IFR);
                    if (coin())
                        add_op(CMD_READ, REG_T1CL, rbyte(), coin());
                end
                2, 3: begin
                    lo = 8'($urandom_range(0, 40));
                    hi = ($urandom_range(0, 7) == 0) ? rbyte() : 8'h00;
                    add_op(CMD_WRITE, REG_T2CL, lo, coin());
                    if (coin())
                        add_op(CMD_WRITE, REG_ACR, rbyte() & ($urandom_range(0, 3) == 0 ?
                               8'hff : 8'hdf), coin());
                    add_op(CMD_WRITE, REG_T2CH, hi, coin());
                    add_ticks(int'(lo) + $urandom_range(1, 20), REG_T2CH, REG_IFR);
                    if (coin())
                        add_op(CMD_READ, REG_T2CL, rbyte(), coin());
                end
                4, 5: begin
                    case ($urandom_range(0, 5))
                        0: mode = SR_IN_T2;
                        1: mode = SR_IN_SYS;
                        2: mode = SR_OUT_FREE;
                        3: mode = SR_OUT_T2;
                        4: mode = SR_OUT_SYS;
                        default: mode = 3'($urandom);
                    endcase
                    add_op(CMD_WRITE, REG_T2CL, 8'($urandom_range(0, 3)), coin());
                    add_op(CMD_WRITE, REG_ACR, {3'($urandom), mode, 2'($urandom)}, coin());
                    if (coin())
                        add_op(CMD_WRITE, REG_SR, rbyte(), coin());
                    else
                        add_op(CMD_READ, REG_SR, rbyte(), coin());
                    add_ticks($urandom_range(4, 64), REG_ORB, REG_IFR);
                    add_op(CMD_READ, REG_SR, rbyte(), coin());
                end
                6: begin
                    v = rbyte();
                    if (coin())
                        v[7:5] = coin() ? PCR_PULSE_MODE : {PCR_STROBE_MODE, coin()};
                    if (coin())
                        v[3:1] = coin() ? PCR_PULSE_MODE : {PCR_STROBE_MODE, coin()};
                    add_op(CMD_WRITE, REG_PCR, v, coin());
                    n = $urandom_range(3, 10);
                    for (int i = 0; i < n; i++) begin
                        case ($urandom_range(0, 5))
                            0: add_op(CMD_READ, REG_ORA, rbyte(), coin());
                            1: add_op(CMD_WRITE, REG_ORA, rbyte(), coin());
                            2: add_op(CMD_WRITE, REG_ORB, rbyte(), coin());
                            3: add_op(CMD_READ, REG_ORA2, rbyte(), coin());
                            4: add_op(CMD_WRITE, REG_ORA2, rbyte(), coin());
                            default: add_op(CMD_TICK, reg_idx_t'($urandom_range(0, 15)),
                                            rbyte(), coin());
                        endcase
                    end
                end
                7: begin
                    add_op(CMD_WRITE, REG_IER, rbyte(), coin());
                    add_op(CMD_WRITE, REG_IFR, rbyte(), coin());
                    add_op(CMD_READ, REG_IFR, rbyte(), coin());
                    add_op(CMD_READ, REG_IER, rbyte(), coin());
                end
                default: begin
                    n = $urandom_range(5, 20);
                    for (int i = 0; i < n; i++)
                        add_op(2'($urandom_range(0, 3)), reg_idx_t'($urandom_range(0, 15)),
                               rbyte(), coin());
                end
            endcase
        end
    endtask

    // sender: bursts of transactions separated by random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge aclk) begin
        bus_op_t op;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || op_taken) begin
            if (gap_left > 0 || pending_ops.size() == 0) begin
                if (gap_left > 0)
                    gap_left--;
                s_valid <= 1'b0;
            end else begin
                op = pending_ops.pop_front();
                s_cmd <= op.cmd;
                s_reg_index <= op.idx;
                s_write_data <= op.data;
                s_compare_in <= op.cmp;
                s_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                            : $urandom_range(1, 12);
                    gap_left = $urandom_range(1, 8);
                end
            end
        end
    end

    // receiver: stall pattern switches between modes every so often
    int rx_mode = 0;
    int rx_left = 0;
    int rx_cyc = 0;

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= (rx_cyc % 3 != 0);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
        rx_cyc++;
    end

    // monitor: predict on input transaction, check on output transaction
    always @(posedge aclk) begin
        bus_op_t   op;
        via_pins_t want, got;
        op_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                op = '{s_cmd, s_reg_index, s_write_data, s_compare_in};
                predict_via_pins(op, want);
                expected_pins.push_back(want);
            end
            if (m_valid && m_ready) begin
                got = '{m_read_data, m_irq, m_timer1_pb7, m_ca2_out, m_cb2_handshake_out,
                        m_cb2_shift_out, m_port_a_out, m_port_b_out};
                if (expected_pins.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transaction at %0t", $realtime);
                end else begin
                    want = expected_pins.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch at %0t (exp/got): rd %h/%h irq %b/%b pb7 %b/%b",
                                     $realtime, want.rd, got.rd, want.irq, got.irq,
                                     want.pb7, got.pb7);
                            $display("  ca2 %b/%b cb2 %b/%b sr %b/%b pa %h/%h pb %h/%h",
                                     want.ca2, got.ca2, want.cb2_hs, got.cb2_hs,
                                     want.cb2_sr, got.cb2_sr, want.pa, got.pa,
                                     want.pb, got.pb);
                        end
                    end
                end
            end
        end
    end

    initial begin
        reset_model();
        load_directed_ops();
        load_random_ops();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        while (pending_ops.size() != 0 || s_valid)
            @(negedge aclk);
        while (expected_pins.size() != 0)
            @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
